>>> rtl/mcqc_pkg.sv
// ----------------------------------------------------------------------------
// mcqc_pkg
// Shared types and constants for the motion counter queue coalescer.
// ----------------------------------------------------------------------------
package mcqc_pkg;

  // Queue geometry and merge limit
  localparam int QUEUE_DEPTH = 256;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int MERGE_MAX   = 32;
  localparam int MCNT_W      = $clog2(MERGE_MAX + 1);

  // Field widths
  localparam int DELTA_W    = 16;
  localparam int GAIN_W     = 10;
  localparam int GAIN_FRAC  = 8;
  localparam int DZ_W       = 15;
  localparam int MAG_W      = DELTA_W + 1;
  localparam int PROD_W     = MAG_W + GAIN_W;
  localparam int ENTRY_W    = 2 * DELTA_W;
  localparam int SUM_W      = DELTA_W + MCNT_W;
  localparam int CMD_W      = 8;
  localparam int COUNT_W    = 6;
  localparam int CMD_LIMIT  = 127;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic              ENABLED_RST = 1'b1;
  localparam logic [DZ_W-1:0]   DZ_RST      = '0;
  localparam logic [GAIN_W-1:0] GAIN_RST    = GAIN_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED   = 2'd0,
    CFG_DEAD_ZONE = 2'd1,
    CFG_GAIN      = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_MOVE  = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_FILTERED = 3'd2,
    ST_EMITTED  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_DRAIN,
    S_DONE
  } state_e;

  typedef struct packed {
    opcode_e                    opcode;
    logic signed [DELTA_W-1:0]  move_dx;
    logic signed [DELTA_W-1:0]  move_dy;
  } in_item_t;

  typedef struct packed {
    status_e                    status;
    logic signed [CMD_W-1:0]    out_x;
    logic signed [CMD_W-1:0]    out_y;
    logic [COUNT_W-1:0]         merged_count;
  } out_item_t;

  // Ring pointer advance with wrap at any depth
  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return n;
  endfunction

endpackage

>>> rtl/mcqc_scale.sv
// ----------------------------------------------------------------------------
// mcqc_scale
// Counteraction scaler: -d * gain / 256, truncated toward zero, saturated.
// ----------------------------------------------------------------------------
module mcqc_scale (
  input  logic                                  clk_i,
  input  logic                                  load_i,
  input  logic signed [mcqc_pkg::DELTA_W-1:0]   d_i,
  input  logic [mcqc_pkg::GAIN_W-1:0]           gain_i,
  output logic signed [mcqc_pkg::DELTA_W-1:0]   scaled_o
);

  localparam int Q_W = mcqc_pkg::PROD_W - mcqc_pkg::GAIN_FRAC;
  localparam logic [Q_W-1:0] POS_MAX = Q_W'((1 << (mcqc_pkg::DELTA_W - 1)) - 1);
  localparam logic [Q_W-1:0] NEG_MAG = Q_W'(1 << (mcqc_pkg::DELTA_W - 1));

  logic signed [mcqc_pkg::MAG_W-1:0] d_ext;
  logic [mcqc_pkg::MAG_W-1:0]        mag;
  logic [mcqc_pkg::PROD_W-1:0]       prod_d, prod_q;
  logic                              neg_d, neg_q;
  logic [Q_W-1:0]                    quot;

  assign d_ext  = mcqc_pkg::MAG_W'(d_i);
  assign mag    = d_ext[mcqc_pkg::MAG_W-1] ? mcqc_pkg::MAG_W'(-d_ext)
                                          : mcqc_pkg::MAG_W'(d_ext);
  assign prod_d = mcqc_pkg::PROD_W'(mag) * mcqc_pkg::PROD_W'(gain_i);
  assign neg_d  = d_i[mcqc_pkg::DELTA_W-1];

  // Register the product before saturation
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
      neg_q  <= neg_d;
    end
  end

  assign quot = prod_q[mcqc_pkg::PROD_W-1:mcqc_pkg::GAIN_FRAC];

  // Negative input gives a positive result and vice versa
  always_comb begin
    if (neg_q) begin
      scaled_o = (quot > POS_MAX) ? mcqc_pkg::DELTA_W'(POS_MAX)
                                  : mcqc_pkg::DELTA_W'(quot);
    end else begin
      scaled_o = (quot > NEG_MAG) ? mcqc_pkg::DELTA_W'(NEG_MAG)
                                  : mcqc_pkg::DELTA_W'(-quot);
    end
  end

endmodule

>>> rtl/motion_counter_queue_coalescer.sv
// ----------------------------------------------------------------------------
// motion_counter_queue_coalescer
// Motion counteraction ring queue with a coalescing drain.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i/in_ready_o/in_data_i): one beat per item. A move
//     beat is filtered, dropped when the queue is full, or scaled by the gain
//     and pushed. A drain beat pops up to MERGE_MAX oldest entries and sums.
//   out channel (out_valid_o/out_ready_i/out_data_o): exactly one result beat
//     per input beat, in order.
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): always
//     ready; write only while the block is idle. Unknown indexes are ignored.
// Timing:
//   A queued move is accepted, then scaled/saturated and written to the queue
//     memory. Filtered, full and empty outcomes resolve in the accept cycle. A
//     drain reads its entries through the single read port of the queue
//     memory, one entry per cycle; the read data is registered, and the sums
//     are clamped once the last entry has been accumulated.
//   The result lands in an output register; the next item is accepted while
//     it waits. If the receiver stalls and a second result is ready, hold it
//     in a side register and stop accepting until the output frees up.
// Reset: pointers clear (queue empty), enabled=1, dead_zone=0, gain=1.0.
//   The queue memory is not cleared; the pointers never expose stale slots.
// ----------------------------------------------------------------------------
module motion_counter_queue_coalescer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  mcqc_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output mcqc_pkg::out_item_t                  out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mcqc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mcqc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int SUM_W = mcqc_pkg::SUM_W;
  localparam logic signed [SUM_W-1:0] LIM_P = SUM_W'(mcqc_pkg::CMD_LIMIT);
  localparam logic signed [SUM_W-1:0] LIM_N = -LIM_P;

  // Configuration registers
  logic                            enabled_q;
  logic [mcqc_pkg::DZ_W-1:0]       dead_zone_q;
  logic [mcqc_pkg::GAIN_W-1:0]     gain_q;

  // Control state
  mcqc_pkg::state_e                state_q, state_d;
  logic [mcqc_pkg::PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [mcqc_pkg::PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [mcqc_pkg::MCNT_W-1:0]     mcnt_q, mcnt_d;
  logic                            rd_vld_q;
  logic                            out_valid_q;

  // Payload registers
  logic signed [SUM_W-1:0]         sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  mcqc_pkg::out_item_t             out_q, res_q, res_d, res;
  logic [mcqc_pkg::ENTRY_W-1:0]    rd_data_q;

  // Queue memory
  logic [mcqc_pkg::ENTRY_W-1:0]    queue_mem [mcqc_pkg::QUEUE_DEPTH];

  // Control strobes
  logic                            accept, is_move, filtered, q_full, q_empty;
  logic                            fin, slot_free, out_load, mem_we, rd_issue;
  logic signed [mcqc_pkg::MAG_W-1:0] dx_ext, dy_ext;
  logic [mcqc_pkg::MAG_W-1:0]      abs_x, abs_y;
  logic signed [mcqc_pkg::DELTA_W-1:0] scaled_x, scaled_y;

  function automatic logic signed [mcqc_pkg::CMD_W-1:0] clamp_cmd(
      input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = (v > LIM_P) ? LIM_P : ((v < LIM_N) ? LIM_N : v);
    return mcqc_pkg::CMD_W'(c);
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= mcqc_pkg::ENABLED_RST;
      dead_zone_q <= mcqc_pkg::DZ_RST;
      gain_q      <= mcqc_pkg::GAIN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mcqc_pkg::CFG_ENABLED:   enabled_q   <= cfg_data_i[0];
        mcqc_pkg::CFG_DEAD_ZONE: dead_zone_q <= cfg_data_i[mcqc_pkg::DZ_W-1:0];
        mcqc_pkg::CFG_GAIN:      gain_q      <= cfg_data_i[mcqc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Move classification on the incoming beat
  assign accept   = in_valid_i && in_ready_o;
  assign is_move  = (in_data_i.opcode == mcqc_pkg::OP_MOVE);
  assign dx_ext   = mcqc_pkg::MAG_W'(in_data_i.move_dx);
  assign dy_ext   = mcqc_pkg::MAG_W'(in_data_i.move_dy);
  assign abs_x    = dx_ext[mcqc_pkg::MAG_W-1] ? mcqc_pkg::MAG_W'(-dx_ext)
                                             : mcqc_pkg::MAG_W'(dx_ext);
  assign abs_y    = dy_ext[mcqc_pkg::MAG_W-1] ? mcqc_pkg::MAG_W'(-dy_ext)
                                             : mcqc_pkg::MAG_W'(dy_ext);
  assign filtered = ((in_data_i.move_dx == '0) && (in_data_i.move_dy == '0)) ||
                    !enabled_q ||
                    ((abs_x < mcqc_pkg::MAG_W'(dead_zone_q)) &&
                     (abs_y < mcqc_pkg::MAG_W'(dead_zone_q)));
  assign q_full   = (mcqc_pkg::next_slot(wr_ptr_q) == rd_ptr_q);
  assign q_empty  = (wr_ptr_q == rd_ptr_q);
  assign slot_free = !out_valid_q || out_ready_i;

  mcqc_scale u_scale_x (
    .clk_i    (clk_i),
    .load_i   (accept),
    .d_i      (in_data_i.move_dx),
    .gain_i   (gain_q),
    .scaled_o (scaled_x)
  );

  mcqc_scale u_scale_y (
    .clk_i    (clk_i),
    .load_i   (accept),
    .d_i      (in_data_i.move_dy),
    .gain_i   (gain_q),
    .scaled_o (scaled_y)
  );

  always_comb begin
    state_d    = state_q;
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    mcnt_d     = mcnt_q;
    sum_x_d    = sum_x_q;
    sum_y_d    = sum_y_q;
    res        = '0;
    res.status = mcqc_pkg::ST_QUEUED;
    res_d      = res_q;
    fin        = 1'b0;
    out_load   = 1'b0;
    mem_we     = 1'b0;
    rd_issue   = 1'b0;
    in_ready_o = 1'b0;

    case (state_q)
      mcqc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (is_move) begin
            if (filtered) begin
              fin        = 1'b1;
              res.status = mcqc_pkg::ST_FILTERED;
            end else if (q_full) begin
              fin        = 1'b1;
              res.status = mcqc_pkg::ST_FULL;
            end else begin
              state_d = mcqc_pkg::S_PUSH;
            end
          end else if (q_empty) begin
            fin        = 1'b1;
            res.status = mcqc_pkg::ST_EMPTY;
          end else begin
            mcnt_d  = '0;
            sum_x_d = '0;
            sum_y_d = '0;
            state_d = mcqc_pkg::S_DRAIN;
          end
        end
      end
      mcqc_pkg::S_PUSH: begin
        // Write the saturated pair, advance the write pointer
        mem_we     = 1'b1;
        wr_ptr_d   = mcqc_pkg::next_slot(wr_ptr_q);
        fin        = 1'b1;
        res.status = mcqc_pkg::ST_QUEUED;
      end
      mcqc_pkg::S_DRAIN: begin
        // Issue one read per cycle, accumulate the entry from the last cycle
        rd_issue = (rd_ptr_q != wr_ptr_q) &&
                   (mcnt_q != mcqc_pkg::MCNT_W'(mcqc_pkg::MERGE_MAX));
        if (rd_issue) begin
          rd_ptr_d = mcqc_pkg::next_slot(rd_ptr_q);
          mcnt_d   = mcnt_q + mcqc_pkg::MCNT_W'(1);
        end
        if (rd_vld_q) begin
          sum_x_d = sum_x_q + SUM_W'($signed(rd_data_q[mcqc_pkg::DELTA_W-1:0]));
          sum_y_d = sum_y_q +
                    SUM_W'($signed(rd_data_q[mcqc_pkg::ENTRY_W-1:mcqc_pkg::DELTA_W]));
        end
        if (!rd_issue && !rd_vld_q) begin
          fin              = 1'b1;
          res.status       = mcqc_pkg::ST_EMITTED;
          res.out_x        = clamp_cmd(sum_x_q);
          res.out_y        = clamp_cmd(sum_y_q);
          res.merged_count = mcqc_pkg::COUNT_W'(mcnt_q);
        end
      end
      mcqc_pkg::S_DONE: begin
        fin = 1'b1;
        res = res_q;
      end
      default: begin
        state_d = mcqc_pkg::S_IDLE;
      end
    endcase

    // Hand the result to the output register, or park it while stalled
    if (fin) begin
      if (slot_free) begin
        out_load = 1'b1;
        state_d  = mcqc_pkg::S_IDLE;
      end else begin
        res_d   = res;
        state_d = mcqc_pkg::S_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcqc_pkg::S_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      mcnt_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      mcnt_q   <= mcnt_d;
      rd_vld_q <= rd_issue;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_x_q <= sum_x_d;
    sum_y_q <= sum_y_d;
    res_q   <= res_d;
    if (out_load) begin
      out_q <= res;
    end
  end

  // Queue memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      queue_mem[wr_ptr_q] <= {scaled_y, scaled_x};
    end
    if (rd_issue) begin
      rd_data_q <= queue_mem[rd_ptr_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/mcqc_checker.sv
// ----------------------------------------------------------------------------
// mcqc_checker
// Port-level checks for the motion counter queue coalescer.
// ----------------------------------------------------------------------------
module mcqc_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  input  mcqc_pkg::out_item_t                  out_data_o
);

  // A stalled result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // Only an emitted command carries nonzero command fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != mcqc_pkg::ST_EMITTED) |->
      (out_data_o.out_x == '0) && (out_data_o.out_y == '0) &&
      (out_data_o.merged_count == '0))
    else $error("non-command result with nonzero fields");

  // Clamp never lets the most negative code through
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.out_x != 8'sh80) && (out_data_o.out_y != 8'sh80))
    else $error("command outside clamp range");

endmodule

bind motion_counter_queue_coalescer mcqc_checker u_mcqc_checker (.*);
